### hdl/rid_pkg.sv
// ----------------------------------------------------------------------------
// rid_pkg: shared types and codes of the instruction decoder
// Item payloads, mnemonic and format codes, opcode and function field values.
// ----------------------------------------------------------------------------
package rid_pkg;

    // Item payloads
    typedef struct packed {
        logic [31:0] instr_word;
        logic        restart;
    } t_rid_in;

    typedef struct packed {
        logic               valid_res;
        logic [5:0]         mnemonic;
        logic [3:0]         format;
        logic [4:0]         rs_num;
        logic [4:0]         rt_num;
        logic [4:0]         rd_num;
        logic [4:0]         shamt;
        logic signed [15:0] imm_value;
        logic [19:0]        break_code;
        logic [31:0]        dest;
    } t_rid_out;

    // Mnemonic codes, in table order
    typedef enum logic [5:0] {
        MN_ADD, MN_ADDU, MN_SUB, MN_SUBU, MN_AND, MN_OR, MN_XOR, MN_NOR,
        MN_SLL, MN_SRL, MN_SRA, MN_SLLV, MN_SRLV, MN_SRAV, MN_SLT, MN_SLTU,
        MN_MULT, MN_MULTU, MN_DIV, MN_DIVU, MN_JR, MN_JALR, MN_SYSCALL, MN_BREAK,
        MN_MFHI, MN_MFLO, MN_MTHI, MN_MTLO, MN_ADDI, MN_ADDIU, MN_ORI, MN_ANDI,
        MN_XORI, MN_LUI, MN_SLTI, MN_SLTIU, MN_LW, MN_LB, MN_LBU, MN_LH,
        MN_LHU, MN_SW, MN_SH, MN_SB, MN_BEQ, MN_BNE, MN_BGEZ, MN_BGTZ,
        MN_BLEZ, MN_BLTZ, MN_J, MN_JAL, MN_MFC0, MN_MTC0, MN_ERET
    } t_mnem;

    // Operand format classes
    typedef enum logic [3:0] {
        FM_R, FM_RA, FM_RST, FM_RS, FM_RSD, FM_RD, FM_SYS, FM_BRK,
        FM_I, FM_LUI, FM_SI, FM_J, FM_COP0, FM_ERET
    } t_fmt;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes under OP_SPECIAL
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    // rt codes under OP_REGIMM, rs codes under OP_COP0
    localparam logic [4:0] RT_BLTZ    = 5'd0;
    localparam logic [4:0] RT_BGEZ    = 5'd1;
    localparam logic [4:0] RS_MFC0    = 5'd0;
    localparam logic [4:0] RS_MTC0    = 5'd4;

    // The one accepted exception return word
    localparam logic [31:0] ERET_WORD = 32'h4200_0018;

    // Program counter step per word
    localparam logic [31:0] PC_STEP   = 32'd4;

endpackage

### hdl/rid_ifs.sv
// ----------------------------------------------------------------------------
// rid_ifs: item channels of the instruction decoder
// Valid/ready channels carrying an instruction item in and a decode item out.
// ----------------------------------------------------------------------------
interface rid_in_if import rid_pkg::*; ();
    logic    valid;
    logic    ready;
    t_rid_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rid_out_if import rid_pkg::*; ();
    logic     valid;
    logic     ready;
    t_rid_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/risc_instruction_decoder.sv
// Path: an accepted item sits in the input register, is decoded there and moves
// into the result register once that register is free or drains, and its
// result leaves from there.
// Throughput: one item per cycle while the output is ready; the pc increment
// sits at the input register and the branch target adder at the result register.
// Reset (i_rst_n low, synchronous) empties both stages and clears the pc.
// ----------------------------------------------------------------------------
// risc_instruction_decoder: MIPS-I instruction word decoder
// Classifies each word, checks zero fields, extracts fields and computes the
// branch destination against a running program counter; a jump passes its target field.
// ----------------------------------------------------------------------------
module risc_instruction_decoder import rid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rid_in_if.sink    i_in,
    rid_out_if.source o_out
);

    logic [31:0] r_prog_counter;
    logic        r_s1_valid;
    logic [31:0] r_s1_word;
    logic [31:0] r_s1_pc;
    logic        r_out_valid;
    t_rid_out    r_out;

    logic        s1_advance;
    logic        in_take;
    logic [31:0] n_pc;
    t_rid_out    n_out;

    // Handshake: stage one moves on when the output register is free or drains
    assign s1_advance  = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_s1_valid || s1_advance;
    assign in_take     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Program counter: cleared by restart, then stepped for every item
    assign n_pc = (i_in.data.restart ? 32'd0 : r_prog_counter) + PC_STEP;

    // Decode of the word held in stage one
    always_comb begin
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic        ok;
        t_mnem       mn;
        t_fmt        fm;
        logic [31:0] offset;

        op     = r_s1_word[31:26];
        rs     = r_s1_word[25:21];
        rt     = r_s1_word[20:16];
        rd     = r_s1_word[15:11];
        sa     = r_s1_word[10:6];
        fn     = r_s1_word[5:0];
        ok     = 1'b1;
        mn     = MN_ADD;
        fm     = FM_I;
        offset = {{14{r_s1_word[15]}}, r_s1_word[15:0], 2'b00};

        unique case (op)
            OP_SPECIAL: begin
                unique case (fn) inside
                    [FN_ADD:FN_NOR]: begin
                        mn = t_mnem'({3'b000, fn[2:0]});
                        fm = FM_R;
                        ok = (sa == 5'd0);
                    end
                    FN_SLL:     begin mn = MN_SLL;  fm = FM_RA; ok = (rs == 5'd0); end
                    FN_SRL:     begin mn = MN_SRL;  fm = FM_RA; ok = (rs == 5'd0); end
                    FN_SRA:     begin mn = MN_SRA;  fm = FM_RA; ok = (rs == 5'd0); end
                    FN_SLLV:    begin mn = MN_SLLV; fm = FM_R;  ok = (sa == 5'd0); end
                    FN_SRLV:    begin mn = MN_SRLV; fm = FM_R;  ok = (sa == 5'd0); end
                    FN_SRAV:    begin mn = MN_SRAV; fm = FM_R;  ok = (sa == 5'd0); end
                    FN_SLT:     begin mn = MN_SLT;  fm = FM_R;  ok = (sa == 5'd0); end
                    FN_SLTU:    begin mn = MN_SLTU; fm = FM_R;  ok = (sa == 5'd0); end
                    [FN_MULT:FN_DIVU]: begin
                        mn = t_mnem'(6'(MN_MULT) + {4'b0000, fn[1:0]});
                        fm = FM_RST;
                        ok = (rd == 5'd0) && (sa == 5'd0);
                    end
                    FN_JR: begin
                        mn = MN_JR;
                        fm = FM_RS;
                        ok = (rt == 5'd0) && (rd == 5'd0) && (sa == 5'd0);
                    end
                    FN_JALR: begin
                        mn = MN_JALR;
                        fm = FM_RSD;
                        ok = (rt == 5'd0) && (sa == 5'd0);
                    end
                    // syscall and break carry a free code field
                    FN_SYSCALL: begin mn = MN_SYSCALL; fm = FM_SYS; end
                    FN_BREAK:   begin mn = MN_BREAK;   fm = FM_BRK; end
                    FN_MFHI, FN_MFLO: begin
                        mn = (fn == FN_MFHI) ? MN_MFHI : MN_MFLO;
                        fm = FM_RD;
                        ok = (rs == 5'd0) && (rt == 5'd0) && (sa == 5'd0);
                    end
                    FN_MTHI, FN_MTLO: begin
                        mn = (fn == FN_MTHI) ? MN_MTHI : MN_MTLO;
                        fm = FM_RS;
                        ok = (rt == 5'd0) && (rd == 5'd0) && (sa == 5'd0);
                    end
                    default: ok = 1'b0;
                endcase
            end
            OP_ADDI:  mn = MN_ADDI;
            OP_ADDIU: mn = MN_ADDIU;
            OP_ORI:   mn = MN_ORI;
            OP_ANDI:  mn = MN_ANDI;
            OP_XORI:  mn = MN_XORI;
            OP_LUI:   begin mn = MN_LUI; fm = FM_LUI; ok = (rs == 5'd0); end
            OP_SLTI:  mn = MN_SLTI;
            OP_SLTIU: mn = MN_SLTIU;
            OP_LW:    mn = MN_LW;
            OP_LB:    mn = MN_LB;
            OP_LBU:   mn = MN_LBU;
            OP_LH:    mn = MN_LH;
            OP_LHU:   mn = MN_LHU;
            OP_SW:    mn = MN_SW;
            OP_SH:    mn = MN_SH;
            OP_SB:    mn = MN_SB;
            OP_BEQ:   mn = MN_BEQ;
            OP_BNE:   mn = MN_BNE;
            OP_REGIMM: begin
                fm = FM_SI;
                mn = (rt == RT_BGEZ) ? MN_BGEZ : MN_BLTZ;
                ok = (rt == RT_BGEZ) || (rt == RT_BLTZ);
            end
            OP_BGTZ:  begin mn = MN_BGTZ; fm = FM_SI; ok = (rt == 5'd0); end
            OP_BLEZ:  begin mn = MN_BLEZ; fm = FM_SI; ok = (rt == 5'd0); end
            OP_J:     begin mn = MN_J;    fm = FM_J; end
            OP_JAL:   begin mn = MN_JAL;  fm = FM_J; end
            OP_COP0: begin
                // exact eret word first, then the coprocessor moves
                if (r_s1_word == ERET_WORD) begin
                    mn = MN_ERET;
                    fm = FM_ERET;
                end else begin
                    fm = FM_COP0;
                    mn = (rs == RS_MFC0) ? MN_MFC0 : MN_MTC0;
                    ok = (r_s1_word[10:0] == 11'd0) &&
                         ((rs == RS_MFC0) || (rs == RS_MTC0));
                end
            end
            default: ok = 1'b0;
        endcase

        // Result assembly; raw fields pass through whatever the word
        n_out.valid_res  = ok;
        n_out.mnemonic   = ok ? 6'(mn) : 6'd0;
        n_out.format     = ok ? 4'(fm) : 4'd0;
        n_out.rs_num     = rs;
        n_out.rt_num     = rt;
        n_out.rd_num     = rd;
        n_out.shamt      = sa;
        n_out.imm_value  = r_s1_word[15:0];
        n_out.break_code = (ok && mn == MN_BREAK) ? r_s1_word[25:6] : 20'd0;
        if (ok && (fm == FM_SI || mn == MN_BEQ || mn == MN_BNE)) begin
            n_out.dest = r_s1_pc + offset;
        end else if (ok && fm == FM_J) begin
            n_out.dest = {6'd0, r_s1_word[25:0]};
        end else begin
            n_out.dest = 32'd0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_counter <= 32'd0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_take) begin
                r_prog_counter <= n_pc;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_word <= i_in.data.instr_word;
            r_s1_pc   <= n_pc;
        end
        if (s1_advance && r_s1_valid) begin
            r_out <= n_out;
        end
    end

endmodule
